[sv/block_buffer_cache_manager_top_macros.svh]
// assertion macros shared by the buffer cache manager modules
// no dependencies; included by the controller and the datapath
`ifndef BLOCK_BUFFER_CACHE_MANAGER_TOP_MACROS_SVH
`define BLOCK_BUFFER_CACHE_MANAGER_TOP_MACROS_SVH

// same-cycle implication
`define BBCM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBCM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bbcm_pkg.sv]
// types, codes and constants of the block buffer cache manager
// no dependencies; imported by every module of the block
`default_nettype none

package bbcm_pkg;

    localparam int BUFFERS_DEFAULT = 8;
    localparam int TAG_W           = 32;
    localparam int CNT_W           = 8;
    localparam int OP_W            = 2;
    localparam int IDX_W           = 3;
    localparam int ST_W            = 2;

    localparam logic [TAG_W-1:0] UNTAGGED = '1;
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_FORGET  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_HELD  = 2'd2;
    localparam logic [ST_W-1:0] ST_SATURATED = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic lookup;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

[sv/bbcm_ctrl.sv]
// controller state machine: request capture, tag lookup, update and result valid
// depends on bbcm_pkg and block_buffer_cache_manager_top_macros.svh
`default_nettype none
`include "block_buffer_cache_manager_top_macros.svh"

module bbcm_ctrl
    import bbcm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_LOOKUP;
            end
            S_LOOKUP: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (!m_valid_reg || m_ready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.load   = (state_reg == S_IDLE) && s_valid && aresetn;
        cmd.lookup = (state_reg == S_LOOKUP);
        cmd.exec   = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
        s_ready    = (state_reg == S_IDLE) && aresetn;
        m_valid    = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    `BBCM_ASSERT_NEXT(a_accept_lookup, aclk, aresetn, s_valid && s_ready, cmd.lookup, "accepted request not looked up")
    `BBCM_ASSERT_NEXT(a_exec_result, aclk, aresetn, cmd.exec, m_valid, "update gave no result")
    `BBCM_ASSERT_NOW(a_no_overwrite, aclk, aresetn, m_valid && !m_ready, !cmd.exec, "pending result overwritten")

endmodule

`default_nettype wire

[sv/bbcm_datapath.sv]
// datapath: tags, contents-valid bits, use counts, free queue and result register
// depends on bbcm_pkg and block_buffer_cache_manager_top_macros.svh
`default_nettype none
`include "block_buffer_cache_manager_top_macros.svh"

module bbcm_datapath
    import bbcm_pkg::*;
#(
    parameter int BUFFERS = BUFFERS_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmd_t             cmd,
    input  wire logic [OP_W-1:0]  s_operation,
    input  wire logic [TAG_W-1:0] s_block_number,
    input  wire logic [IDX_W-1:0] s_buffer_index,
    output logic      [ST_W-1:0]  m_status,
    output logic      [IDX_W-1:0] m_slot,
    output logic                  m_hit,
    output logic                  m_need_fill,
    output logic      [CNT_W-1:0] m_count_after
);

    localparam int SLOT_W = $clog2(BUFFERS);
    localparam int LEN_W  = $clog2(BUFFERS + 1);

    // captured request
    logic [OP_W-1:0]  op_reg;
    logic [TAG_W-1:0] blk_reg;
    logic [IDX_W-1:0] idx_reg;

    // lookup result
    logic [BUFFERS-1:0] match_reg, match_next;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  hit_slot_reg, hit_slot_next;

    // buffer state
    logic [TAG_W-1:0]  tag_reg   [BUFFERS];
    logic [TAG_W-1:0]  tag_next  [BUFFERS];
    logic [BUFFERS-1:0] vld_reg, vld_next;
    logic [CNT_W-1:0]  cnt_reg   [BUFFERS];
    logic [CNT_W-1:0]  cnt_next  [BUFFERS];
    logic [SLOT_W-1:0] queue_reg [BUFFERS];
    logic [SLOT_W-1:0] queue_next[BUFFERS];
    logic [LEN_W-1:0]  len_reg, len_next;

    // result
    logic [ST_W-1:0]  st_reg, st_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             hit_reg, hit_next;
    logic             fill_reg, fill_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic               is_lookup;
    logic               in_range;
    logic [SLOT_W-1:0]  sel;
    logic [CNT_W-1:0]   cur_cnt;
    logic [CNT_W-1:0]   new_cnt;
    logic               base_valid;
    logic               fill;
    logic [BUFFERS-1:0] pos_match;
    logic [BUFFERS-1:0] shift_en;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_operation;
            blk_reg <= s_block_number;
            idx_reg <= s_buffer_index;
        end
        if (cmd.lookup) begin
            match_reg    <= match_next;
            found_reg    <= found_next;
            hit_slot_reg <= hit_slot_next;
        end
        if (cmd.exec) begin
            st_reg    <= st_next;
            slot_reg  <= slot_next;
            hit_reg   <= hit_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUFFERS; i++) begin
                tag_reg[i]   <= UNTAGGED;
                cnt_reg[i]   <= '0;
                queue_reg[i] <= SLOT_W'(i);
            end
            vld_reg <= '0;
            len_reg <= LEN_W'(BUFFERS);
        end else if (cmd.exec) begin
            tag_reg   <= tag_next;
            cnt_reg   <= cnt_next;
            queue_reg <= queue_next;
            vld_reg   <= vld_next;
            len_reg   <= len_next;
        end
    end

    // tag compare across all slots, lowest match wins
    always_comb begin
        found_next    = 1'b0;
        hit_slot_next = '0;
        for (int i = 0; i < BUFFERS; i++) begin
            match_next[i] = (tag_reg[i] == blk_reg) && (blk_reg != UNTAGGED);
        end
        for (int i = BUFFERS - 1; i >= 0; i--) begin
            if (match_next[i]) begin
                found_next    = 1'b1;
                hit_slot_next = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        logic run;
        is_lookup = (op_reg == OP_GET) || (op_reg == OP_READ);
        in_range  = (32'(idx_reg) < BUFFERS);
        if (is_lookup) begin
            sel = found_reg ? hit_slot_reg : queue_reg[0];
        end else begin
            sel = SLOT_W'(idx_reg);
        end
        cur_cnt    = cnt_reg[sel];
        base_valid = found_reg && vld_reg[sel];
        fill       = (op_reg == OP_READ) && !base_valid;
        new_cnt    = cur_cnt;

        // free queue position of the selected slot
        run = 1'b0;
        for (int i = 0; i < BUFFERS; i++) begin
            pos_match[i] = (i < int'(len_reg)) && (queue_reg[i] == sel);
            run          = run | pos_match[i];
            shift_en[i]  = run;
        end

        tag_next   = tag_reg;
        cnt_next   = cnt_reg;
        queue_next = queue_reg;
        vld_next   = vld_reg;
        len_next   = len_reg;

        st_next    = ST_OK;
        slot_next  = '0;
        hit_next   = 1'b0;
        fill_next  = 1'b0;
        count_next = '0;

        if (is_lookup) begin
            if (!found_reg && (len_reg == '0)) begin
                st_next = ST_NO_FREE;
            end else begin
                if (found_reg) begin
                    if (cur_cnt == CNT_MAX) begin
                        st_next = ST_SATURATED;
                    end else begin
                        new_cnt = cur_cnt + 1'b1;
                    end
                end else begin
                    new_cnt       = CNT_W'(1);
                    tag_next[sel] = blk_reg;
                end
                if (!found_reg || (cur_cnt == '0)) begin
                    for (int i = 0; i < BUFFERS - 1; i++) begin
                        if (shift_en[i]) queue_next[i] = queue_reg[i + 1];
                    end
                    len_next = len_reg - 1'b1;
                end
                cnt_next[sel] = new_cnt;
                vld_next[sel] = base_valid | fill;
                slot_next     = IDX_W'(sel);
                hit_next      = found_reg;
                fill_next     = fill;
                count_next    = new_cnt;
            end
        end else begin
            slot_next = idx_reg;
            if (!in_range || (cur_cnt == '0)) begin
                st_next = ST_NOT_HELD;
            end else begin
                new_cnt       = cur_cnt - 1'b1;
                cnt_next[sel] = new_cnt;
                count_next    = new_cnt;
                if (new_cnt == '0) begin
                    queue_next[len_reg[SLOT_W-1:0]] = sel;
                    len_next = len_reg + 1'b1;
                    if (op_reg == OP_FORGET) begin
                        tag_next[sel] = UNTAGGED;
                        vld_next[sel] = 1'b0;
                    end
                end
            end
        end
    end

    assign m_status      = st_reg;
    assign m_slot        = slot_reg;
    assign m_hit         = hit_reg;
    assign m_need_fill   = fill_reg;
    assign m_count_after = count_reg;

    `BBCM_ASSERT_NOW(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LEN_W'(BUFFERS), "free queue overflow")
    `BBCM_ASSERT_NOW(a_single_match, aclk, aresetn, cmd.exec, $countones(match_reg) <= 1, "block tagged in two buffers")
    `BBCM_ASSERT_NOW(a_idle_hit_queued, aclk, aresetn, cmd.exec && is_lookup && found_reg && (cur_cnt == '0), |pos_match, "idle buffer missing from free queue")

endmodule

`default_nettype wire

[sv/block_buffer_cache_manager_top.sv]
// Block buffer cache tag manager. Each request is a get, read, release or
// forget on a pool of BUFFERS buffers; each gives exactly one result.
// An accepted request passes the tag compare across all slots, then the
// use count and free queue update, which loads the result register. The
// block is ready again the cycle after the update, so a new request is not
// taken until the previous one has been through its update. A new request
// is accepted while the previous result may still be waiting; a result
// that is not taken holds the update of the next one. Ready is low during
// reset.
// Depends on bbcm_pkg, bbcm_ctrl and bbcm_datapath.
`default_nettype none

module block_buffer_cache_manager_top
    import bbcm_pkg::*;
#(
    parameter int BUFFERS = BUFFERS_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [OP_W-1:0]  s_operation,
    input  wire logic [TAG_W-1:0] s_block_number,
    input  wire logic [IDX_W-1:0] s_buffer_index,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [ST_W-1:0]  m_status,
    output logic      [IDX_W-1:0] m_slot,
    output logic                  m_hit,
    output logic                  m_need_fill,
    output logic      [CNT_W-1:0] m_count_after
);

    cmd_t cmd;

    bbcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    bbcm_datapath #(
        .BUFFERS (BUFFERS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_operation    (s_operation),
        .s_block_number (s_block_number),
        .s_buffer_index (s_buffer_index),
        .m_status       (m_status),
        .m_slot         (m_slot),
        .m_hit          (m_hit),
        .m_need_fill    (m_need_fill),
        .m_count_after  (m_count_after)
    );

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench for block_buffer_cache_manager_top: directed table, saturation run,
// then random get/read/release/forget traffic checked against a buffer pool predictor
// depends on bbcm_pkg and block_buffer_cache_manager_top
module testbench
    import bbcm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUFS        = BUFFERS_DEFAULT;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_REQS = 1350;
    localparam int HOLD_AFTER  = 700;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] slot;
        logic             hit;
        logic             need_fill;
        logic [CNT_W-1:0] count_after;
    } result_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] blk;
        logic [IDX_W-1:0] idx;
        bit               typed;
        result_t          res;
    } row_t;

    logic             aclk           = 1'b0;
    logic             aresetn        = 1'b0;
    logic             s_valid        = 1'b0;
    logic             s_ready;
    logic [OP_W-1:0]  s_operation    = OP_GET;
    logic [TAG_W-1:0] s_block_number = '0;
    logic [IDX_W-1:0] s_buffer_index = '0;
    logic             m_valid;
    logic             m_ready        = 1'b0;
    logic [ST_W-1:0]  m_status;
    logic [IDX_W-1:0] m_slot;
    logic             m_hit;
    logic             m_need_fill;
    logic [CNT_W-1:0] m_count_after;

    // predicted buffer pool state
    logic [TAG_W-1:0] pool_tag[BUFS];
    logic             pool_valid[BUFS];
    logic [CNT_W-1:0] pool_count[BUFS];
    logic [IDX_W-1:0] free_slots[$];

    result_t     pending_results[$];
    row_t        directed_rows[$];
    logic [TAG_W-1:0] hot_blocks[12];
    int          errors       = 0;
    int          results_seen = 0;
    int          requests     = 0;
    int          n_hits = 0, n_fills = 0, n_saturated = 0, n_no_free = 0, n_not_held = 0;
    int          stall_cycles = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          calm         = 1'b0;

    block_buffer_cache_manager_top #(.BUFFERS(BUFS)) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_block_number (s_block_number),
        .s_buffer_index (s_buffer_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot         (m_slot),
        .m_hit          (m_hit),
        .m_need_fill    (m_need_fill),
        .m_count_after  (m_count_after)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic result_t pool_apply(input logic [OP_W-1:0] op,
                                           input logic [TAG_W-1:0] blk,
                                           input logic [IDX_W-1:0] idx);
        result_t r;
        int      s;
        int      at;
        bit      found;
        r     = '0;
        s     = 0;
        at    = -1;
        found = 1'b0;
        if (op == OP_GET || op == OP_READ) begin
            if (blk != UNTAGGED) begin
                for (int k = BUFS - 1; k >= 0; k--) begin
                    if (pool_tag[k] == blk) begin
                        s     = k;
                        found = 1'b1;
                    end
                end
            end
            if (found) begin
                if (pool_count[s] == '0) begin
                    foreach (free_slots[k])
                        if (free_slots[k] == IDX_W'(s)) at = k;
                    if (at >= 0) free_slots.delete(at);
                end
                if (pool_count[s] == CNT_MAX) r.status = ST_SATURATED;
                else pool_count[s] = pool_count[s] + 1'b1;
            end else begin
                if (free_slots.size() == 0) begin
                    r.status = ST_NO_FREE;
                    return r;
                end
                s             = int'(free_slots.pop_front());
                pool_tag[s]   = blk;
                pool_count[s] = CNT_W'(1);
                pool_valid[s] = 1'b0;
            end
            if (op == OP_READ && !pool_valid[s]) begin
                r.need_fill   = 1'b1;
                pool_valid[s] = 1'b1;
            end
            r.slot        = IDX_W'(s);
            r.hit         = found;
            r.count_after = pool_count[s];
        end else begin
            r.slot = idx;
            if (int'(idx) >= BUFS || pool_count[idx] == '0) begin
                r.status = ST_NOT_HELD;
                return r;
            end
            pool_count[idx] = pool_count[idx] - 1'b1;
            if (pool_count[idx] == '0) begin
                free_slots.push_back(idx);
                if (op == OP_FORGET) begin
                    pool_tag[idx]   = UNTAGGED;
                    pool_valid[idx] = 1'b0;
                end
            end
            r.count_after = pool_count[idx];
        end
        return r;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] blk,
                           input logic [IDX_W-1:0] idx, input bit typed,
                           input logic [ST_W-1:0] st, input logic [IDX_W-1:0] slot,
                           input logic hit, input logic fill, input logic [CNT_W-1:0] cnt);
        row_t row;
        row.op    = op;
        row.blk   = blk;
        row.idx   = idx;
        row.typed = typed;
        row.res   = {st, slot, hit, fill, cnt};
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] blk,
                                input logic [IDX_W-1:0] idx, input bit typed,
                                input result_t typed_res);
        result_t r;
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_block_number <= blk;
        s_buffer_index <= idx;
        do @(posedge aclk); while (!s_ready);
        r = pool_apply(op, blk, idx);
        if (typed) r = typed_res;
        pending_results.push_back(r);
        requests++;
        n_hits      += r.hit;
        n_fills     += r.need_fill;
        n_saturated += (r.status == ST_SATURATED);
        n_no_free   += (r.status == ST_NO_FREE);
        n_not_held  += (r.status == ST_NOT_HELD);
        if (!calm && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // result checker
    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_slot, m_hit, m_need_fill, m_count_after};
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request waiting:", $time);
                $display("%0t:          actual   status %0d slot %0d hit %0d fill %0d count %0d",
                         $time, got.status, got.slot, got.hit, got.need_fill,
                         got.count_after);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected status %0d slot %0d hit %0d fill %0d count %0d",
                             $time, want.status, want.slot, want.hit, want.need_fill,
                             want.count_after);
                    $display("%0t:          actual   status %0d slot %0d hit %0d fill %0d count %0d",
                             $time, got.status, got.slot, got.hit, got.need_fill,
                             got.count_after);
                    errors++;
                end
            end
        end
    end

    // receiver with random stalls and one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 11);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [IDX_W-1:0] held[$];
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] blk;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] sat_blk;
        int               sat_slot;
        int               pick;
        for (int k = 0; k < BUFS; k++) begin
            pool_tag[k]   = UNTAGGED;
            pool_valid[k] = 1'b0;
            pool_count[k] = '0;
            free_slots.push_back(IDX_W'(k));
        end
        foreach (hot_blocks[k]) hot_blocks[k] = $urandom;

        add_row(OP_GET,     32'h0000_0000, 3'd0, 1'b1, ST_OK,       3'd0, 1'b0, 1'b0, 8'd1);
        add_row(OP_READ,    32'h0000_0000, 3'd0, 1'b1, ST_OK,       3'd0, 1'b1, 1'b1, 8'd2);
        add_row(OP_READ,    32'h0000_0000, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_RELEASE, 32'h0000_0000, 3'd5, 1'b1, ST_NOT_HELD, 3'd5, 1'b0, 1'b0, 8'd0);
        add_row(OP_FORGET,  32'hFFFF_FFFF, 3'd7, 1'b1, ST_NOT_HELD, 3'd7, 1'b0, 1'b0, 8'd0);
        add_row(OP_GET,     UNTAGGED,      3'd0, 1'b1, ST_OK,       3'd1, 1'b0, 1'b0, 8'd1);
        add_row(OP_READ,    UNTAGGED,      3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_READ,    32'hFFFF_FFFE, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_GET,     32'hAAAA_AAAA, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_GET,     32'h5555_5555, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_READ,    32'h8000_0000, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_GET,     32'h0000_0001, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_GET,     32'h1234_5678, 3'd0, 1'b1, ST_NO_FREE,  3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_READ,    32'hDEAD_BEEF, 3'd0, 1'b1, ST_NO_FREE,  3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_GET,     32'hAAAA_AAAA, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_RELEASE, 32'h0000_0000, 3'd4, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_FORGET,  32'h0000_0000, 3'd4, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_GET,     32'hAAAA_AAAA, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_RELEASE, 32'h0000_0000, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_RELEASE, 32'h0000_0000, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_RELEASE, 32'h0000_0000, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_GET,     32'h0000_0000, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_FORGET,  32'h0000_0000, 3'd6, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_READ,    32'h8000_0000, 3'd0, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);
        add_row(OP_RELEASE, 32'h0000_0000, 3'd1, 1'b0, ST_OK,       3'd0, 1'b0, 1'b0, 8'd0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].op, directed_rows[r].blk, directed_rows[r].idx,
                         directed_rows[r].typed, directed_rows[r].res);

        // give every held buffer back
        for (int k = 0; k < BUFS; k++)
            while (pool_count[k] != '0)
                send_request(OP_RELEASE, $urandom, IDX_W'(k), 1'b0, '0);
        wait_drained();

        // drive one buffer to count saturation, then forget it down to free
        do sat_blk = $urandom; while (sat_blk == UNTAGGED);
        for (int n = 0; n < 260; n++)
            send_request((n == 257) ? OP_READ : OP_GET, sat_blk, 3'($urandom), 1'b0, '0);
        sat_slot = 0;
        for (int k = 0; k < BUFS; k++)
            if (pool_tag[k] == sat_blk) sat_slot = k;
        for (int n = 0; n < 256; n++)
            send_request(OP_FORGET, $urandom, IDX_W'(sat_slot), 1'b0, '0);
        wait_drained();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            calm = (n >= 300 && n < 600);
            held.delete();
            for (int k = 0; k < BUFS; k++)
                if (pool_count[k] != '0) held.push_back(IDX_W'(k));
            pick = $urandom_range(0, 99);
            blk  = $urandom;
            idx  = IDX_W'($urandom_range(0, 7));
            if (pick < 49) begin
                op = $urandom_range(0, 1) ? OP_READ : OP_GET;
                if (pick < 40) blk = hot_blocks[$urandom_range(0, 11)];
                else if (pick >= 47) blk = UNTAGGED;
            end else begin
                op = $urandom_range(0, 1) ? OP_FORGET : OP_RELEASE;
                if (pick < 92 && held.size() > 0)
                    idx = held[$urandom_range(0, held.size() - 1)];
            end
            send_request(op, blk, idx, 1'b0, '0);
        end
        calm = 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("%0d requests, %0d results: %0d hits, %0d fills, %0d saturated,",
                 requests, results_seen, n_hits, n_fills, n_saturated);
        $display("%0d with no free buffer, %0d releases of buffers not held, %0d mismatches",
                 n_no_free, n_not_held, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/bbcm_pkg.sv
sv/bbcm_ctrl.sv
sv/bbcm_datapath.sv
sv/block_buffer_cache_manager_top.sv
tb/testbench.sv
